// ===== hw/rtl/kqt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kqt_pkg
// Shared types and constants of the keyed quantity table: table size,
// operation and status codes, the word formats and the lookup summary.
// ----------------------------------------------------------------------------
package kqt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = 5;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_GET    = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND    = 2'd1;
  localparam logic [1:0] ST_INSUFFICIENT = 2'd2;
  localparam logic [1:0] ST_FULL         = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] item_id;
    logic [31:0] amount;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        stored_quantity;
    logic [ENTRY_W-1:0] entry_count;
  } rsp_t;

  // one slot of the table memory
  typedef struct packed {
    logic [31:0] item_id;
    logic [31:0] amount;
  } slot_t;

  // outcome of the slot search
  typedef struct packed {
    logic        hit;
    logic        free_found;
    logic [31:0] amount;
  } scan_t;

  // what the update stage does to the table
  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      qty;
    logic             wr_en;
    logic [31:0]      wr_amount;
    logic             set_valid;
    logic             clr_valid;
    logic             clear_all;
    logic [CNT_W-1:0] count_next;
  } upd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/kqt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kqt_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module kqt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/kqt_upd.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kqt_upd
// Update stage: from the operation and the search outcome, works out the
// status, reported quantity, the slot write and the new entry count.
// ----------------------------------------------------------------------------
module kqt_upd (
  input  wire  kqt_pkg::req_t             req,
  input  wire  kqt_pkg::scan_t            scan,
  input  wire  logic [kqt_pkg::CNT_W-1:0] occ,
  output kqt_pkg::upd_t                   upd
);
  import kqt_pkg::*;

  logic [32:0] sum;
  logic [31:0] diff;

  assign sum  = {1'b0, scan.amount} + {1'b0, req.amount};
  assign diff = scan.amount - req.amount;

  always_comb begin
    upd            = '0;
    upd.status     = ST_OK;
    upd.count_next = occ;
    case (req.mode)
      MODE_ADD: begin
        if (scan.hit) begin
          // saturate on carry out
          upd.wr_en     = 1'b1;
          upd.wr_amount = sum[32] ? '1 : sum[31:0];
          upd.qty       = upd.wr_amount;
        end else if (scan.free_found) begin
          upd.wr_en      = 1'b1;
          upd.wr_amount  = req.amount;
          upd.set_valid  = 1'b1;
          upd.qty        = req.amount;
          upd.count_next = occ + CNT_W'(1);
        end else begin
          upd.status = ST_FULL;
        end
      end
      MODE_REMOVE: begin
        if (!scan.hit) begin
          upd.status = ST_NOT_FOUND;
        end else if (scan.amount < req.amount) begin
          upd.status = ST_INSUFFICIENT;
          upd.qty    = scan.amount;
        end else begin
          upd.wr_en     = 1'b1;
          upd.wr_amount = diff;
          upd.qty       = diff;
          if (diff == 32'd0) begin
            upd.clr_valid  = 1'b1;
            upd.count_next = occ - CNT_W'(1);
          end
        end
      end
      MODE_GET: begin
        if (scan.hit) begin
          upd.qty = scan.amount;
        end else begin
          upd.status = ST_NOT_FOUND;
        end
      end
      MODE_CLEAR: begin
        upd.clear_all  = 1'b1;
        upd.count_next = '0;
      end
      default: begin
        upd.status = ST_OK;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/keyed_quantity_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_quantity_table
// Table of item id / quantity pairs with add, remove, get and clear.
// ----------------------------------------------------------------------------
// Usage: a request word (mode, item_id, amount) enters on req_valid/req_stall
// and exactly one response word (status, stored_quantity, entry_count) leaves
// on rsp_valid/rsp_stall for each request, in order.
// Slots live in a RAM with a registered read; occupancy is kept in a
// flip-flop vector. Each lookup walks the slots one per cycle, stopping at the
// first match, or walks all CAPACITY slots when there is none. A request is
// taken only in the idle state, so the next request waits until the current
// result has been handed to the output register: the serial slot walk over
// the single RAM read port sets the rate. Clear skips the walk and goes
// straight to the update state.
// Reset empties all slots and zeroes the entry count; slot contents are not
// cleared. The response sits in an output register: a new request is taken
// while it waits, and a finished result that cannot be handed over because
// rsp_stall is high is held until the register frees up.
// ----------------------------------------------------------------------------
module keyed_quantity_table (
  input  wire  logic           clk,
  input  wire  logic           rst,
  input  wire  logic           req_valid,
  output logic                 req_stall,
  input  wire  kqt_pkg::req_t  req,
  output logic                 rsp_valid,
  input  wire  logic           rsp_stall,
  output kqt_pkg::rsp_t        rsp
);
  import kqt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]          state;
  logic [CAPACITY-1:0] valid;
  logic [CNT_W-1:0]    occ;
  req_t                cur;
  logic [CNT_W-1:0]    issue_cnt;
  logic                chk_vld;
  logic [IDX_W-1:0]    chk_idx;
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic [31:0]         hit_amt;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;
  rsp_t                pend;

  logic                accept;
  logic                rsp_free;
  logic                rd_en;
  slot_t               rd_data;
  logic                match;
  logic [IDX_W-1:0]    wr_idx;
  slot_t               wr_data;
  scan_t               scan;
  upd_t                upd;
  rsp_t                res;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign rd_en = (state == S_SCAN) && (issue_cnt < CNT_W'(CAPACITY));
  assign match = chk_vld && valid[chk_idx] && (rd_data.item_id == cur.item_id);

  assign wr_idx          = hit ? hit_idx : free_idx;
  assign wr_data.item_id = cur.item_id;
  assign wr_data.amount  = upd.wr_amount;

  assign scan.hit        = hit;
  assign scan.free_found = free_found;
  assign scan.amount     = hit_amt;

  assign res.status          = upd.status;
  assign res.stored_quantity = upd.qty;
  assign res.entry_count     = ENTRY_W'(upd.count_next);

  kqt_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    ((state == S_UPD) && upd.wr_en),
    .waddr (wr_idx),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (issue_cnt[IDX_W-1:0]),
    .rdata (rd_data)
  );

  kqt_upd u_upd (
    .req  (cur),
    .scan (scan),
    .occ  (occ),
    .upd  (upd)
  );

  // search and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      occ        <= '0;
      chk_vld    <= 1'b0;
      issue_cnt  <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else begin
      chk_vld <= rd_en;
      if (rd_en) begin
        chk_idx   <= issue_cnt[IDX_W-1:0];
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur        <= req;
            issue_cnt  <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= (req.mode == MODE_CLEAR) ? S_UPD : S_SCAN;
          end
        end
        S_SCAN: begin
          if (chk_vld) begin
            if (match) begin
              hit     <= 1'b1;
              hit_idx <= chk_idx;
              hit_amt <= rd_data.amount;
              state   <= S_UPD;
            end else begin
              // remember the lowest empty slot for a claim
              if (!valid[chk_idx] && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= chk_idx;
              end
              if (chk_idx == IDX_W'(CAPACITY - 1)) begin
                state <= S_UPD;
              end
            end
          end
        end
        S_UPD: begin
          occ <= upd.count_next;
          if (upd.clear_all) begin
            valid <= '0;
          end else if (upd.set_valid) begin
            valid[wr_idx] <= 1'b1;
          end else if (upd.clr_valid) begin
            valid[wr_idx] <= 1'b0;
          end
          state <= rsp_free ? S_IDLE : S_RESP;
        end
        S_RESP: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      pend <= res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_free) begin
      if (state == S_UPD) begin
        rsp_valid <= 1'b1;
        rsp       <= res;
      end else if (state == S_RESP) begin
        rsp_valid <= 1'b1;
        rsp       <= pend;
      end else begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(occ))
    else $error("entry count disagrees with occupied slots");

  a_hit_slot_occupied: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) && hit |-> valid[hit_idx])
    else $error("matched slot is not occupied");

  a_lookup_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept && (req.mode != MODE_CLEAR) |=> (state == S_SCAN))
    else $error("lookup request did not start the slot walk");
`endif

endmodule
`default_nettype wire
